/* design/assert_macros.svh */
// Assertion macros shared by the calculator RTL.
// Define NO_ASSERTIONS to compile the design without any checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Checked at every rising edge outside of reset.
`define RPN_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("rpn_stack_calculator: assertion failed");

// Checked at every rising edge, reset included.
`define RPN_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("rpn_stack_calculator: assertion failed");

`else

`define RPN_ASSERT(label, prop)
`define RPN_ASSERT_ALWAYS(label, prop)

`endif

`endif

/* design/rpn_pkg.sv */
`timescale 1ns / 1ps

package rpn_pkg;

    localparam int DEFAULT_STACK_DEPTH = 16;
    localparam int WORD_W              = 32;
    localparam int PEND_W              = 31;
    localparam int DIV_STEPS           = WORD_W;

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [7:0]        key_t;
    typedef logic [2:0]        status_t;
    typedef logic [1:0]        cell_cmd_t;

    // Key codes (ASCII).
    localparam key_t KEY_ZERO     = 8'h30;
    localparam key_t KEY_NINE     = 8'h39;
    localparam key_t KEY_CLEAR    = 8'h43;
    localparam key_t KEY_SHOW_TOP = 8'h70;
    localparam key_t KEY_SHOW_ALL = 8'h50;
    localparam key_t KEY_ADD      = 8'h2B;
    localparam key_t KEY_SUB      = 8'h2D;
    localparam key_t KEY_MUL      = 8'h2A;
    localparam key_t KEY_DIV      = 8'h2F;
    localparam key_t KEY_DUP      = 8'h64;
    localparam key_t KEY_SWAP     = 8'h72;
    localparam key_t KEY_ENTER    = 8'h65;
    localparam key_t KEY_HASH     = 8'h23;
    localparam key_t KEY_SPACE    = 8'h20;

    // Result status codes.
    localparam status_t ST_OK      = 3'd0;
    localparam status_t ST_NUMOVF  = 3'd1;
    localparam status_t ST_BLOCKED = 3'd2;
    localparam status_t ST_UNDER   = 3'd3;
    localparam status_t ST_FULL    = 3'd4;
    localparam status_t ST_DIVZERO = 3'd5;

    // Stack cell commands: where a cell takes its next value from.
    localparam cell_cmd_t CELL_HOLD      = 2'd0;
    localparam cell_cmd_t CELL_FROM_UP   = 2'd1;
    localparam cell_cmd_t CELL_FROM_DOWN = 2'd2;

    // Divider request and response.
    typedef struct packed {
        logic  start;
        word_t dividend;
        word_t divisor;
    } div_req_t;

    typedef struct packed {
        logic  busy;
        word_t quotient;
    } div_rsp_t;

endpackage

/* design/rpn_key_if.sv */
`timescale 1ns / 1ps

interface rpn_key_if;
    import rpn_pkg::*;

    logic valid;
    logic ready;
    key_t key_code;
    logic ops_blocked;

    modport source (output valid, output key_code, output ops_blocked, input ready);
    modport sink   (input valid, input key_code, input ops_blocked, output ready);
endinterface

/* design/rpn_result_if.sv */
`timescale 1ns / 1ps

interface rpn_result_if;
    import rpn_pkg::*;

    logic               valid;
    logic               ready;
    logic signed [31:0] shown_value;
    logic               value_valid;
    status_t            status;
    logic               last_result;

    modport source (output valid, output shown_value, output value_valid,
                    output status, output last_result, input ready);
    modport sink   (input valid, input shown_value, input value_valid,
                    input status, input last_result, output ready);
endinterface

/* design/rpn_stack_calculator.sv */
`timescale 1ns / 1ps
// RPN stack calculator. Each key transfer on the key channel produces one or more
// transfers on the result channel, in order, with last_result set on the final one.
// Digits build a pending number; enter pushes it, and the operators act on a stack of
// STACK_DEPTH signed 32-bit entries kept in a row of cells that shift toward or away
// from the top. A key is taken when the block is idle; ordinary keys then pass through
// capture and execute, execute waiting for the output register to be free, before their
// result sits in the output register, and the next key can be taken while that result
// still waits. Divide also waits for the bit-serial divider, which produces one quotient
// bit per cycle. Show all rotates the whole cell row once, presenting one entry per
// cycle while entries remain and the output side keeps taking them.
`include "assert_macros.svh"

module rpn_stack_calculator #(
    parameter int STACK_DEPTH = rpn_pkg::DEFAULT_STACK_DEPTH
) (
    input  logic         clk,
    input  logic         rst_n,
    rpn_key_if.sink      key,
    rpn_result_if.source result
);
    import rpn_pkg::*;

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int RW = $clog2(STACK_DEPTH);

    // Control states.
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_DUMP = 2'd3;

    // Operations on the whole cell row.
    localparam logic [2:0] OP_HOLD   = 3'd0;
    localparam logic [2:0] OP_PUSH   = 3'd1;
    localparam logic [2:0] OP_BINARY = 3'd2;
    localparam logic [2:0] OP_SWAP   = 3'd3;
    localparam logic [2:0] OP_ROTATE = 3'd4;

    localparam logic [PEND_W+3:0] PEND_MAX = (PEND_W+4)'(32'h7FFF_FFFF);

    logic [1:0]        state_reg, state_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [PEND_W-1:0] pend_reg, pend_next;
    logic [RW-1:0]     rot_reg, rot_next;
    key_t              key_reg;
    logic              blocked_reg;

    logic              out_valid_reg, out_valid_next;
    word_t             out_value_reg, out_value_next;
    logic              out_vvalid_reg, out_vvalid_next;
    status_t           out_status_reg, out_status_next;
    logic              out_last_reg, out_last_next;

    logic              key_accept;
    logic              out_free;
    logic              is_digit;
    logic [PEND_W+3:0] pend_ext;
    logic [PEND_W+3:0] digit_value;
    logic              dump_emit;

    logic              emit;
    word_t             emit_value;
    logic              emit_vvalid;
    status_t           emit_status;
    logic              emit_last;

    logic [2:0]        stack_op;
    word_t             top_load;
    word_t             op_a, op_b;
    word_t             sum, diff, prod, bin_result;

    div_req_t          div_req;
    div_rsp_t          div_rsp;

    word_t             cell_data [STACK_DEPTH];

    // ------------------------------------------------------------------
    // Handshake and datapath helpers
    // ------------------------------------------------------------------
    assign key.ready  = (state_reg == S_IDLE);
    assign key_accept = key.valid && key.ready;

    // A result may be loaded when the output register is empty or drains this cycle.
    assign out_free = !out_valid_reg || result.ready;

    assign is_digit = (key_reg >= KEY_ZERO) && (key_reg <= KEY_NINE);

    // pending * 10 + digit, wide enough that the overflow compare is exact.
    assign pend_ext    = (PEND_W+4)'(pend_reg);
    assign digit_value = (PEND_W+4)'(key_reg[3:0]);

    // b is the top entry, a the one beneath it.
    assign op_b = cell_data[0];
    assign op_a = cell_data[1];
    assign sum  = op_a + op_b;
    assign diff = op_a - op_b;
    assign prod = op_a * op_b;

    always_comb
    begin
        case (key_reg)
            KEY_ADD: bin_result = sum;
            KEY_SUB: bin_result = diff;
            default: bin_result = prod;
        endcase
    end

    assign dump_emit = (CW'(rot_reg) < count_reg);

    // ------------------------------------------------------------------
    // Control
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        pend_next   = pend_reg;
        rot_next    = rot_reg;
        stack_op    = OP_HOLD;
        top_load    = cell_data[0];
        div_req.start    = 1'b0;
        div_req.dividend = op_a;
        div_req.divisor  = op_b;
        emit        = 1'b0;
        emit_value  = '0;
        emit_vvalid = 1'b0;
        emit_status = ST_OK;
        emit_last   = 1'b1;

        case (state_reg)
            S_IDLE:
            begin
                if (key_accept)
                    state_next = S_EXEC;
            end

            S_EXEC:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                    emit       = 1'b1;
                    if (is_digit)
                    begin
                        // A digit that would pass 2^31-1 leaves the number as it was.
                        if (((pend_ext << 3) + (pend_ext << 1) + digit_value) > PEND_MAX)
                            emit_status = ST_NUMOVF;
                        else
                            pend_next = PEND_W'((pend_ext << 3) + (pend_ext << 1)
                                                + digit_value);
                    end
                    else if (blocked_reg)
                    begin
                        emit_status = ST_BLOCKED;
                    end
                    else
                    begin
                        pend_next = '0;
                        case (key_reg)
                            KEY_CLEAR:
                            begin
                                count_next = '0;
                            end
                            KEY_SHOW_TOP:
                            begin
                                if (count_reg == '0)
                                    emit_status = ST_UNDER;
                                else
                                begin
                                    emit_value  = cell_data[0];
                                    emit_vvalid = 1'b1;
                                end
                            end
                            KEY_SHOW_ALL:
                            begin
                                // An empty stack answers with a single empty result.
                                if (count_reg != '0)
                                begin
                                    emit       = 1'b0;
                                    state_next = S_DUMP;
                                    rot_next   = '0;
                                end
                            end
                            KEY_ADD, KEY_SUB, KEY_MUL:
                            begin
                                if (count_reg < CW'(2))
                                    emit_status = ST_UNDER;
                                else
                                begin
                                    stack_op   = OP_BINARY;
                                    top_load   = bin_result;
                                    count_next = count_reg - 1'b1;
                                end
                            end
                            KEY_DIV:
                            begin
                                if (count_reg < CW'(2))
                                    emit_status = ST_UNDER;
                                else if (op_b == '0)
                                    emit_status = ST_DIVZERO;
                                else
                                begin
                                    emit          = 1'b0;
                                    div_req.start = 1'b1;
                                    state_next    = S_DIV;
                                end
                            end
                            KEY_DUP:
                            begin
                                if (count_reg == '0)
                                    emit_status = ST_UNDER;
                                else if (count_reg == CW'(STACK_DEPTH))
                                    emit_status = ST_FULL;
                                else
                                begin
                                    stack_op   = OP_PUSH;
                                    top_load   = cell_data[0];
                                    count_next = count_reg + 1'b1;
                                end
                            end
                            KEY_SWAP:
                            begin
                                if (count_reg < CW'(2))
                                    emit_status = ST_UNDER;
                                else
                                    stack_op = OP_SWAP;
                            end
                            KEY_ENTER, KEY_HASH, KEY_SPACE:
                            begin
                                if (count_reg == CW'(STACK_DEPTH))
                                    emit_status = ST_FULL;
                                else
                                begin
                                    stack_op   = OP_PUSH;
                                    top_load   = word_t'(pend_reg);
                                    count_next = count_reg + 1'b1;
                                end
                            end
                            default:
                            begin
                                // Unknown keys only clear the pending number.
                            end
                        endcase
                    end
                end
            end

            S_DIV:
            begin
                // The quotient replaces the two operands once the divider is done.
                if (!div_rsp.busy && out_free)
                begin
                    stack_op   = OP_BINARY;
                    top_load   = div_rsp.quotient;
                    count_next = count_reg - 1'b1;
                    emit       = 1'b1;
                    state_next = S_IDLE;
                end
            end

            S_DUMP:
            begin
                // The row turns once completely so that it ends where it started.
                // Entries in use are presented on the way; the rest pass silently.
                if (!dump_emit || out_free)
                begin
                    stack_op = OP_ROTATE;
                    if (dump_emit)
                    begin
                        emit        = 1'b1;
                        emit_value  = cell_data[0];
                        emit_vvalid = 1'b1;
                        emit_last   = ((CW'(rot_reg) + CW'(1)) == count_reg);
                    end
                    if (rot_reg == RW'(STACK_DEPTH - 1))
                        state_next = S_IDLE;
                    else
                        rot_next = rot_reg + 1'b1;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output register: loads a new result or empties once it has been taken.
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_value_next  = out_value_reg;
        out_vvalid_next = out_vvalid_reg;
        out_status_next = out_status_reg;
        out_last_next   = out_last_reg;
        if (emit)
        begin
            out_valid_next  = 1'b1;
            out_value_next  = emit_value;
            out_vvalid_next = emit_vvalid;
            out_status_next = emit_status;
            out_last_next   = emit_last;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            pend_reg      <= '0;
            rot_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            pend_reg      <= pend_next;
            rot_reg       <= rot_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (key_accept)
        begin
            key_reg     <= key.key_code;
            blocked_reg <= key.ops_blocked;
        end
        out_value_reg  <= out_value_next;
        out_vvalid_reg <= out_vvalid_next;
        out_status_reg <= out_status_next;
        out_last_reg   <= out_last_next;
    end

    assign result.valid       = out_valid_reg;
    assign result.shown_value = $signed(out_value_reg);
    assign result.value_valid = out_vvalid_reg;
    assign result.status      = out_status_reg;
    assign result.last_result = out_last_reg;

    // ------------------------------------------------------------------
    // Stack cell row. Cell 0 is the top of the stack; its upper input is the
    // value being pushed or written, and the deepest cell's lower input wraps
    // around to cell 0 so that the row can rotate.
    // ------------------------------------------------------------------
    for (genvar i = 0; i < STACK_DEPTH; i++)
    begin : g_cell
        cell_cmd_t cmd;
        word_t     up_data;
        word_t     down_data;

        always_comb
        begin
            case (stack_op)
                OP_PUSH:   cmd = CELL_FROM_UP;
                OP_BINARY: cmd = (i == 0) ? CELL_FROM_UP : CELL_FROM_DOWN;
                OP_SWAP:
                begin
                    if (i == 0)
                        cmd = CELL_FROM_DOWN;
                    else if (i == 1)
                        cmd = CELL_FROM_UP;
                    else
                        cmd = CELL_HOLD;
                end
                OP_ROTATE: cmd = CELL_FROM_DOWN;
                default:   cmd = CELL_HOLD;
            endcase
        end

        assign up_data   = (i == 0) ? top_load : cell_data[(i == 0) ? 0 : i - 1];
        assign down_data = cell_data[(i == STACK_DEPTH - 1) ? 0 : i + 1];

        rpn_cell u_cell (
            .clk       (clk),
            .cmd       (cmd),
            .up_data   (up_data),
            .down_data (down_data),
            .data      (cell_data[i])
        );
    end

    rpn_divider u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `RPN_ASSERT(a_count_bound, count_reg <= CW'(STACK_DEPTH))
    `RPN_ASSERT(a_shown_is_ok, out_valid_reg && out_vvalid_reg |-> out_status_reg == ST_OK)
    `RPN_ASSERT(a_div_only_in_div, div_rsp.busy |-> state_reg == S_DIV)
    `RPN_ASSERT(a_dump_nonempty, state_reg == S_DUMP |-> count_reg != '0)
endmodule

/* design/rpn_cell.sv */
`timescale 1ns / 1ps

module rpn_cell (
    input  logic               clk,
    input  rpn_pkg::cell_cmd_t cmd,
    input  rpn_pkg::word_t     up_data,
    input  rpn_pkg::word_t     down_data,
    output rpn_pkg::word_t     data
);
    import rpn_pkg::*;

    word_t data_reg;
    word_t data_next;

    always_comb
    begin
        case (cmd)
            CELL_FROM_UP:   data_next = up_data;
            CELL_FROM_DOWN: data_next = down_data;
            default:        data_next = data_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;
endmodule

/* design/rpn_divider.sv */
`timescale 1ns / 1ps

module rpn_divider (
    input  logic              clk,
    input  logic              rst_n,
    input  rpn_pkg::div_req_t req,
    output rpn_pkg::div_rsp_t rsp
);
    import rpn_pkg::*;

    localparam int CNT_W = $clog2(DIV_STEPS);

    logic             busy_reg, busy_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    word_t            rem_reg, rem_next;
    word_t            quot_reg, quot_next;
    word_t            dsr_reg, dsr_next;
    logic             neg_reg, neg_next;

    word_t             a_mag;
    word_t             b_mag;
    logic [WORD_W:0]   rem_shift;
    logic [WORD_W:0]   rem_sub;

    // Magnitudes; the most negative value maps to 2^31 as an unsigned word.
    assign a_mag = req.dividend[WORD_W-1] ? (~req.dividend + 1'b1) : req.dividend;
    assign b_mag = req.divisor[WORD_W-1]  ? (~req.divisor + 1'b1)  : req.divisor;

    assign rem_shift = {rem_reg, quot_reg[WORD_W-1]};
    assign rem_sub   = rem_shift - {1'b0, dsr_reg};

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quot_next = quot_reg;
        dsr_next  = dsr_reg;
        neg_next  = neg_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DIV_STEPS - 1);
            rem_next  = '0;
            quot_next = a_mag;
            dsr_next  = b_mag;
            neg_next  = req.dividend[WORD_W-1] ^ req.divisor[WORD_W-1];
        end
        else if (busy_reg)
        begin
            // One restoring step: one quotient bit per cycle.
            if (!rem_sub[WORD_W])
            begin
                rem_next  = rem_sub[WORD_W-1:0];
                quot_next = {quot_reg[WORD_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_shift[WORD_W-1:0];
                quot_next = {quot_reg[WORD_W-2:0], 1'b0};
            end
            if (cnt_reg == '0)
                busy_next = 1'b0;
            else
                cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
        dsr_reg  <= dsr_next;
        neg_reg  <= neg_next;
    end

    assign rsp.busy     = busy_reg;
    assign rsp.quotient = neg_reg ? (~quot_reg + 1'b1) : quot_reg;
endmodule
